FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of the date difference unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a at one edge implies b at the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// a at one edge implies b at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

// a at one edge implies b at a later edge
`define ASSERT_AFTER2(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##2 (b)) \
    else $error(msg);

`endif

FILE: rtl/core/cddu_pkg.sv
// Types, constants and helper functions of the date difference unit.
`timescale 1ns / 1ps
package cddu_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DOY_W   = 9;   // up to 366 + 31
  localparam int unsigned BASE_W  = 23;  // days before Jan 1 of year 16383
  localparam int unsigned LEAP_W  = 13;  // leap years before a year
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned DIFF_W  = 25;  // signed span of two bases

  localparam int unsigned YEAR_RAW_MAX = (1 << YEAR_W) - 1;

  localparam logic [BASE_W-1:0]  DAYS_COMMON = 23'd365;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  // ceil(2^20 / 100); exact quotient for all 14-bit inputs
  localparam logic [YEAR_W-1:0] RECIP100 = 14'd10486;
  localparam int unsigned RECIP_SH = 20;

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic               include_end;
  } cddu_in_t;

  typedef struct packed {
    logic               in_order;
    logic [COUNT_W-1:0] day_count;
  } cddu_out_t;

  // one date reduced to clamped year, day of year and days before its Jan 1
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    logic [BASE_W-1:0] base;
  } cddu_date_t;

  // days before the first of a month in a common year; 13..15 are a full year
  function automatic logic [DOY_W-1:0] months_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] v;
    unique case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd365;
    endcase
    return v;
  endfunction

  // floor(x / 100) by reciprocal multiply
  function automatic logic [7:0] div100(input logic [YEAR_W-1:0] x);
    logic [2*YEAR_W-1:0] p;
    p = (2*YEAR_W)'(x) * (2*YEAR_W)'(RECIP100);
    return p[RECIP_SH +: 8];
  endfunction

endpackage

FILE: rtl/core/cddu_date_conv.sv
// Converts one date into clamped year, day of year and day base.
`timescale 1ns / 1ps
module cddu_date_conv #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic [cddu_pkg::YEAR_W-1:0]  year,
  input  logic [cddu_pkg::MONTH_W-1:0] month,
  input  logic [cddu_pkg::DAY_W-1:0]   day,
  output cddu_pkg::cddu_date_t         date
);

  localparam logic [cddu_pkg::YEAR_W-1:0] CLAMP_YEAR = cddu_pkg::YEAR_W'(
    (MAX_YEAR > cddu_pkg::YEAR_RAW_MAX) ? cddu_pkg::YEAR_RAW_MAX : MAX_YEAR);

  logic [cddu_pkg::YEAR_W-1:0] yc;
  logic [7:0]                  q;
  logic [cddu_pkg::YEAR_W-1:0] hundreds;
  logic                        rem_nz;
  logic                        q4_nz;
  logic                        leap;
  logic [cddu_pkg::LEAP_W-1:0] quarters;
  logic [cddu_pkg::LEAP_W-1:0] leaps;

  always_comb begin
    yc       = (year > CLAMP_YEAR) ? CLAMP_YEAR : year;
    q        = cddu_pkg::div100(yc);
    hundreds = (cddu_pkg::YEAR_W'(q) << 6) + (cddu_pkg::YEAR_W'(q) << 5)
             + (cddu_pkg::YEAR_W'(q) << 2);
    rem_nz   = (yc != hundreds);
    q4_nz    = (q[1:0] != 2'd0);
    leap     = ((yc[1:0] == 2'd0) && rem_nz) || (!rem_nz && !q4_nz);
    // ceil(y/4) - ceil(y/100) + ceil(y/400)
    quarters = cddu_pkg::LEAP_W'(({1'b0, yc} + 15'd3) >> 2);
    leaps    = quarters - (cddu_pkg::LEAP_W'(q) + cddu_pkg::LEAP_W'(rem_nz))
             + (cddu_pkg::LEAP_W'(q[7:2]) + cddu_pkg::LEAP_W'(rem_nz || q4_nz));

    date.year = yc;
    date.doy  = cddu_pkg::months_before(month)
              + cddu_pkg::DOY_W'((month >= 4'd3) && leap)
              + cddu_pkg::DOY_W'(day);
    date.base = cddu_pkg::BASE_W'(yc) * cddu_pkg::DAYS_COMMON
              + cddu_pkg::BASE_W'(leaps);
  end

endmodule

FILE: rtl/core/cddu_span.sv
// Orders two converted dates and forms the saturated day count.
`timescale 1ns / 1ps
module cddu_span (
  input  cddu_pkg::cddu_date_t date_a,
  input  cddu_pkg::cddu_date_t date_b,
  input  logic                 include_end,
  output cddu_pkg::cddu_out_t  res
);

  logic                                ordered;
  logic signed [cddu_pkg::DIFF_W-1:0] diff;

  always_comb begin
    ordered = (date_a.year != date_b.year) ? (date_a.year < date_b.year)
                                           : (date_a.doy < date_b.doy);
    diff = $signed(cddu_pkg::DIFF_W'(date_b.base)) - $signed(cddu_pkg::DIFF_W'(date_a.base))
         + $signed(cddu_pkg::DIFF_W'(date_b.doy)) - $signed(cddu_pkg::DIFF_W'(date_a.doy))
         + $signed(cddu_pkg::DIFF_W'(include_end));

    res.in_order = ordered;
    priority if (!ordered || diff < 0) begin
      res.day_count = '0;
    end else if (diff > $signed(cddu_pkg::DIFF_W'(cddu_pkg::COUNT_MAX))) begin
      res.day_count = cddu_pkg::COUNT_MAX;
    end else begin
      res.day_count = diff[cddu_pkg::COUNT_W-1:0];
    end
  end

endmodule

FILE: rtl/core/calendar_date_difference_unit.sv
// Top level of the Gregorian date difference unit.
// An accepted item strobes its result on out_valid once through the input, date and result registers.
// Throughput: one item per cycle; three register stages (input, date, result), no stall.
// busy is high only while rst_n is low; the receiver cannot hold results off.
// Reset (synchronous, active low) clears the stage valid bits; payload is not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module calendar_date_difference_unit #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cddu_pkg::cddu_in_t  in_item,
  output logic                out_valid,
  output cddu_pkg::cddu_out_t out_item
);

  // Stage 0: input register
  cddu_pkg::cddu_in_t   item_r;
  logic                 item_valid_r;
  logic                 accept;

  // Stage 1: both dates reduced to (year, day of year, day base)
  cddu_pkg::cddu_date_t date_a_nxt, date_b_nxt;
  cddu_pkg::cddu_date_t date_a_r, date_b_r;
  logic                 inc_r;
  logic                 date_valid_r;

  // Stage 2: result register
  cddu_pkg::cddu_out_t  out_nxt;
  cddu_pkg::cddu_out_t  out_r;
  logic                 out_valid_r;

  // Nothing ever backs up, so the only time an item is refused is reset.
  assign busy   = ~rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      date_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= accept;
      date_valid_r <= item_valid_r;
      out_valid_r  <= date_valid_r;
    end
  end

  // Payload moves every cycle; the valid bits say which slots are real.
  always_ff @(posedge clk) begin
    item_r   <= in_item;
    date_a_r <= date_a_nxt;
    date_b_r <= date_b_nxt;
    inc_r    <= item_r.include_end;
    out_r    <= out_nxt;
  end

  // Start date: clamp year, leap test, day of year, days before Jan 1.
  cddu_date_conv #(
    .MAX_YEAR(MAX_YEAR)
  ) u_conv_a (
    .year (item_r.first_year),
    .month(item_r.first_month),
    .day  (item_r.first_day),
    .date (date_a_nxt)
  );

  // End date: same conversion.
  cddu_date_conv #(
    .MAX_YEAR(MAX_YEAR)
  ) u_conv_b (
    .year (item_r.second_year),
    .month(item_r.second_month),
    .day  (item_r.second_day),
    .date (date_b_nxt)
  );

  // Ordering test, base difference and saturation to the count range.
  cddu_span u_span (
    .date_a     (date_a_r),
    .date_b     (date_b_r),
    .include_end(inc_r),
    .res        (out_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // An item held in the input register strobes out after the date and result registers.
  `ASSERT_AFTER2(a_accept_to_result, clk, rst_n, item_valid_r, out_valid, "item lost in pipe")
  // Identical dates can never be reported as ordered.
  `ASSERT_NEXT(a_same_date_unordered, clk, rst_n,
    date_valid_r && (date_a_r.year == date_b_r.year) && (date_a_r.doy == date_b_r.doy),
    !out_item.in_order, "equal dates flagged in order")
  // An unordered pair always carries a zero count.
  `ASSERT_IMPL(a_unordered_zero, clk, rst_n, out_valid && !out_item.in_order,
    out_item.day_count == '0, "nonzero count on unordered pair")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the Gregorian date difference unit.
`timescale 1ns / 1ps
module testbench;

  // Year cap handed to the block; years above it count as this year.
  localparam int YEAR_CAP = 9999;
  // Cycles with neither an accepted item nor a result before the run is called hung.
  localparam int QUIET_LIMIT = 2000;
  // The block strobes a result once an item has passed its input, date and result registers; drain after that.
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 530;

  // Days before the first of each month in a common year. Month 0 behaves like
  // January, months 13..15 like a date past the end of December.
  localparam int DAYS_BEFORE_MONTH [0:15] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
  };

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  cddu_pkg::cddu_in_t  in_item;
  logic                out_valid;
  cddu_pkg::cddu_out_t out_item;

  calendar_date_difference_unit #(
    .MAX_YEAR(YEAR_CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // date pairs waiting to be driven, and spans expected back from the block
  cddu_pkg::cddu_in_t  date_pairs[$];
  cddu_pkg::cddu_out_t due_spans[$];

  logic taken;          // item accepted at the last rising edge
  int   issued;         // items taken off date_pairs by the driver
  int   total_items;
  int   quiet_cycles;
  int   mismatches;
  int   spans_checked;
  int   ordered_seen;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Date arithmetic of the predictor
  // ---------------------------------------------------------------------------

  function automatic longint capped_year(logic [cddu_pkg::YEAR_W-1:0] y);
    return (y > YEAR_CAP) ? longint'(YEAR_CAP) : longint'(y);
  endfunction

  function automatic bit is_leap(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // leap years in [0, y); year 0 itself is a leap year
  function automatic longint leap_years_below(longint y);
    return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  // day number within the year; day is never range checked
  function automatic longint day_number(longint y, logic [cddu_pkg::MONTH_W-1:0] m,
                                        logic [cddu_pkg::DAY_W-1:0] d);
    longint n;
    n = DAYS_BEFORE_MONTH[m];
    if (m >= 3 && is_leap(y))
      n++;
    return n + longint'(d);
  endfunction

  // Expected result for one date pair. An unordered pair gives zero; an ordered
  // pair whose unchecked days push the sum below zero clamps at zero too.
  function automatic cddu_pkg::cddu_out_t predict_span(cddu_pkg::cddu_in_t p);
    longint              y1, y2, n1, n2, span;
    bit                  ordered;
    cddu_pkg::cddu_out_t r;
    y1 = capped_year(p.first_year);
    y2 = capped_year(p.second_year);
    n1 = day_number(y1, p.first_month, p.first_day);
    n2 = day_number(y2, p.second_month, p.second_day);
    ordered = (y1 != y2) ? (y1 < y2) : (n1 < n2);
    span = 0;
    if (ordered) begin
      span = n2 - n1 + longint'(p.include_end);
      if (y2 > y1)
        span += 365 * (y2 - y1) + leap_years_below(y2) - leap_years_below(y1);
      if (span < 0)
        span = 0;
      if (span > longint'(cddu_pkg::COUNT_MAX))
        span = longint'(cddu_pkg::COUNT_MAX);
    end
    r.in_order  = ordered;
    r.day_count = span[cddu_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int month_len(int y, int m);
    if (m == 2)
      return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11)
      return 30;
    return 31;
  endfunction

  task automatic add_pair(int y1, int m1, int d1, int y2, int m2, int d2, int inc);
    cddu_pkg::cddu_in_t p;
    p.first_year   = y1[cddu_pkg::YEAR_W-1:0];
    p.first_month  = m1[cddu_pkg::MONTH_W-1:0];
    p.first_day    = d1[cddu_pkg::DAY_W-1:0];
    p.second_year  = y2[cddu_pkg::YEAR_W-1:0];
    p.second_month = m2[cddu_pkg::MONTH_W-1:0];
    p.second_day   = d2[cddu_pkg::DAY_W-1:0];
    p.include_end  = inc[0];
    date_pairs.push_back(p);
  endtask

  // Mostly calendar-valid dates, with same-year and nearby-year pairs so that
  // both orderings show up; a fifth of the items are raw field noise.
  task automatic add_random_pair();
    int kind, y1, y2, m1, m2, d1, d2;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      add_pair($urandom_range(0, cddu_pkg::YEAR_RAW_MAX), $urandom_range(0, 15),
               $urandom_range(0, 31), $urandom_range(0, cddu_pkg::YEAR_RAW_MAX),
               $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 1));
    end else begin
      y1 = $urandom_range(0, YEAR_CAP);
      case (kind)
        2, 3, 4: y2 = y1;
        5, 6:    y2 = $urandom_range(0, YEAR_CAP);
        default: begin
          y2 = y1 + $urandom_range(0, 8) - 4;
          if (y2 < 0)
            y2 = 0;
          if (y2 > YEAR_CAP)
            y2 = YEAR_CAP;
        end
      endcase
      m1 = $urandom_range(1, 12);
      m2 = (kind == 4) ? m1 : $urandom_range(1, 12);
      d1 = $urandom_range(1, month_len(y1, m1));
      d2 = $urandom_range(1, month_len(y2, m2));
      add_pair(y1, m1, d1, y2, m2, d2, $urandom_range(0, 1));
    end
  endtask

  // sender idling per phase: light, then heavy, then none
  function automatic int idle_pct();
    if (issued < total_items / 3)
      return 18;
    if (issued < 2 * total_items / 3)
      return 61;
    return 0;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. start stays up across
  // back-to-back items and only drops when the sender idles or runs dry.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (date_pairs.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
        in_item <= date_pairs.pop_front();
        start   <= 1'b1;
        issued  <= issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on the rising edge, check any strobed result against the oldest
  // expectation, then record the expectation for an item accepted at this edge.
  // Also runs the watchdog on cycles where nothing moves.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cddu_pkg::cddu_out_t want;
    if (!rst_n) begin
      taken        <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      taken <= start && !busy;
      if (out_valid) begin
        if (due_spans.size() == 0) begin
          // a result strobed with no item outstanding
          report_mismatch("outstanding items", 1, 0);
        end else begin
          want = due_spans.pop_front();
          spans_checked++;
          if (want.in_order)
            ordered_seen++;
          if (out_item.in_order !== want.in_order)
            report_mismatch("in_order", want.in_order, out_item.in_order);
          if (out_item.day_count !== want.day_count)
            report_mismatch("day_count", want.day_count, out_item.day_count);
        end
      end
      if (start && !busy)
        due_spans.push_back(predict_span(in_item));
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $realtime, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the item queue, reset, let the driver run, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    issued        = 0;
    mismatches    = 0;
    spans_checked = 0;
    ordered_seen  = 0;

    // directed corner cases
    add_pair(2024, 3, 10, 2024, 3, 10, 0);          // same date
    add_pair(2024, 3, 10, 2024, 3, 10, 1);          // same date, end day counted
    add_pair(2020, 5, 1, 2019, 5, 1, 1);            // reversed
    add_pair(0, 1, 1, 9999, 12, 31, 0);             // full year range
    add_pair(0, 1, 1, 9999, 12, 31, 1);
    add_pair(0, 1, 1, 0, 1, 2, 0);                  // one day in year 0
    add_pair(2000, 2, 28, 2000, 3, 1, 0);           // 400-year leap
    add_pair(1900, 2, 28, 1900, 3, 1, 0);           // century, not leap
    add_pair(2023, 12, 31, 2024, 1, 1, 1);          // across new year
    add_pair(cddu_pkg::YEAR_RAW_MAX, 1, 1, 9999, 1, 1, 0);  // year above cap equals cap
    add_pair(9998, 6, 1, cddu_pkg::YEAR_RAW_MAX, 6, 2, 0);  // capped end year
    add_pair(2010, 0, 5, 2010, 1, 6, 0);            // month zero acts as January
    add_pair(2010, 12, 31, 2010, 15, 31, 0);        // month past December
    add_pair(2012, 13, 1, 2012, 14, 1, 1);          // both past December, leap year
    add_pair(2011, 3, 0, 2011, 3, 1, 0);            // day zero
    add_pair(2011, 2, 31, 2011, 3, 1, 0);           // overlong February day
    add_pair(5, 15, 31, 6, 0, 0, 0);                // ordered but negative sum
    add_pair(5, 15, 31, 6, 0, 0, 1);
    add_pair(0, 0, 0, 0, 0, 0, 0);                  // all fields low
    add_pair(0, 0, 0, cddu_pkg::YEAR_RAW_MAX, 15, 31, 1);   // all fields high on the end date
    add_pair(cddu_pkg::YEAR_RAW_MAX, 15, 31, 0, 0, 0, 1);   // all fields high on the start date
    add_pair(1999, 12, 31, 2000, 12, 31, 1);        // leap year span

    repeat (RANDOM_ITEMS)
      add_random_pair();
    total_items = date_pairs.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all items handed over and every expectation answered
    while (date_pairs.size() != 0 || start || due_spans.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d date pairs (%0d directed), idle phases 18%%, 61%%, 0%%.",
             issued, total_items - RANDOM_ITEMS);
    $display("Checked %0d spans: %0d ordered, %0d unordered; %0d mismatches.",
             spans_checked, ordered_seen, spans_checked - ordered_seen, mismatches);
    if (mismatches == 0 && due_spans.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
